[hw/rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the timed step sequencer
// Request and response word layouts, mode codes and fixed-point constants.
// ----------------------------------------------------------------------------
package tss_pkg;

   // request modes
   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_PLAY   = 2'd2;
   localparam logic [1:0] MODE_UPDATE = 2'd3;

   // 1.0 in unsigned 16.16
   localparam logic [31:0] FP_ONE = 32'h0001_0000;

   // most response words a single request may produce
   localparam int unsigned MAX_RESULTS = 16;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] duration;
      logic [31:0] time_step;
   } req_type;

   typedef struct packed {
      logic       event_res;
      logic [3:0] step_index;
      logic       full_error;
      logic       done_res;
      logic       completed_now;
      logic       last;
   } rsp_type;

endpackage

[hw/rtl/timed_step_sequencer.sv]
// ----------------------------------------------------------------------------
// timed_step_sequencer: table of step durations walked by elapsed time
// A request word pushes a duration, clears the table, restarts play or
// advances the elapsed time; response words announce entered steps and
// close every request with one final word marked last.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one request word (mode, duration,
// time_step); req_ready is high only while the sequencer is idle. Every
// request returns its step words on the rsp_ channel, then one final word
// with last set. The rsp_ output is a register, so a new request is taken
// while the final word of the previous one still waits for rsp_ready.
// Operation: push and clear go straight to their final word; play first
// sends a step word for step 0 when the table holds steps. An update
// walks its steps through memory read, compare/subtract and send, one
// step per pass through the single compare/subtract unit.
// A new request is accepted only once the final word of the previous one
// is loaded and the sequencer is back in idle.
// A stalled receiver holds the sequencer in its send or finish state;
// nothing is dropped. Reset empties the table, zeroes the elapsed time
// and current step, and clears any pending response; the duration memory
// itself keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module timed_step_sequencer #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tss_pkg::rsp_type rsp_data
);

   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned N_W    = $clog2(tss_pkg::MAX_RESULTS);
   localparam logic [N_W-1:0] N_STOP = N_W'(tss_pkg::MAX_RESULTS - 2);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_SEND = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [2:0]       after_ff, after_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [31:0]      elapsed_ff, elapsed_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0] pend_idx_ff, pend_idx_in;
   logic             full_ff, full_in;
   logic             done_ff, done_in;
   logic             comp_ff, comp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tss_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [31:0]      rd_data_ff;

   logic [31:0]      mem [CAPACITY];
   logic             wr_en;

   logic             accept;
   logic             slot_free;
   logic             load_rsp;
   logic [32:0]      sum;
   logic [32:0]      diff;
   logic             over;
   logic [CNT_W-1:0] cur_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // shared add and compare/subtract unit
   assign sum      = {1'b0, elapsed_ff} + {1'b0, req_data.time_step};
   assign diff     = {1'b0, elapsed_ff} - {1'b0, rd_data_ff};
   assign over     = (rd_data_ff == 32'd0) ? (elapsed_ff > tss_pkg::FP_ONE)
                                           : (!diff[32] && (diff[31:0] != 32'd0));
   assign cur_next = cur_ff + CNT_W'(1);

   // duration memory, one write and one registered read port
   assign wr_en = accept && (req_data.mode == tss_pkg::MODE_PUSH)
                  && (count_ff < CNT_W'(CAPACITY));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= req_data.duration;
      end
      rd_data_ff <= mem[cur_ff[ADDR_W-1:0]];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      after_in    = after_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      elapsed_in  = elapsed_ff;
      n_in        = n_ff;
      pend_idx_in = pend_idx_ff;
      full_in     = full_ff;
      done_in     = done_ff;
      comp_in     = comp_ff;
      load_rsp    = 1'b0;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               full_in  = 1'b0;
               done_in  = 1'b0;
               comp_in  = 1'b0;
               n_in     = '0;
               state_in = ST_FIN;
               unique case (req_data.mode)
                  tss_pkg::MODE_PUSH: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        full_in = 1'b1;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  tss_pkg::MODE_CLEAR: begin
                     count_in   = '0;
                     cur_in     = '0;
                     elapsed_in = '0;
                  end
                  tss_pkg::MODE_PLAY: begin
                     cur_in     = '0;
                     elapsed_in = '0;
                     if (count_ff != '0) begin
                        pend_idx_in = '0;
                        after_in    = ST_FIN;
                        state_in    = ST_SEND;
                     end
                  end
                  tss_pkg::MODE_UPDATE: begin
                     if (cur_ff >= count_ff) begin
                        done_in = 1'b1;
                     end else begin
                        elapsed_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        state_in   = ST_RD;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!over) begin
               state_in = ST_FIN;
            end else begin
               elapsed_in = diff[31:0];
               cur_in     = cur_next;
               if (cur_next >= count_ff) begin
                  done_in  = 1'b1;
                  comp_in  = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  pend_idx_in = cur_next;
                  n_in        = n_ff + N_W'(1);
                  after_in    = (n_ff == N_STOP) ? ST_FIN : ST_RD;
                  state_in    = ST_SEND;
               end
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               load_rsp    = 1'b1;
               rsp_data_in = '{event_res: 1'b1, step_index: 4'(pend_idx_ff),
                               full_error: 1'b0, done_res: 1'b0,
                               completed_now: 1'b0, last: 1'b0};
               state_in    = after_ff;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               load_rsp    = 1'b1;
               rsp_data_in = '{event_res: 1'b0, step_index: 4'd0,
                               full_error: full_ff, done_res: done_ff,
                               completed_now: comp_ff, last: 1'b1};
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         elapsed_ff   <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         elapsed_ff   <= elapsed_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      after_ff    <= after_in;
      pend_idx_ff <= pend_idx_in;
      full_ff     <= full_in;
      done_ff     <= done_in;
      comp_ff     <= comp_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // current step never runs beyond the table fill
   assert property (@(posedge clock) disable iff (reset) cur_ff <= count_ff)
      else $error("current step beyond step count");

   // a compare only happens on a step that exists
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_CMP) |-> (cur_ff < count_ff))
      else $error("compare on a step past the table end");

   // step words per request stay under the result limit
   assert property (@(posedge clock) disable iff (reset)
                    n_ff <= N_W'(tss_pkg::MAX_RESULTS - 1))
      else $error("too many step words in one request");

   // an accepted request always leaves idle
   assert property (@(posedge clock) disable iff (reset)
                    accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // a final word hands control back to idle
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_FIN && slot_free) |=> (state_ff == ST_IDLE)
                    && rsp_valid_ff && rsp_data_ff.last)
      else $error("final word not issued on leaving finish state");
`endif

endmodule
